// ===== rtl/pls_pkg.sv =====
// pls_pkg: shared types and codes for the positional list store
// no dependencies; imported by pls_ctrl and positional_list_store_top
`default_nettype none

package pls_pkg;

	localparam int VALUE_W = 32;
	localparam int POS_W   = 7;
	localparam int COUNT_W = 7;
	localparam int KIND_W  = 2;
	localparam int STAT_W  = 2;

	// request kinds
	localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;
	localparam logic [KIND_W-1:0] KIND_READ   = 2'd3;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0]         kind;
		logic [POS_W-1:0]          position;
		logic signed [VALUE_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] read_value;
		logic [COUNT_W-1:0]        used_count;
		logic [STAT_W-1:0]         status;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/pls_mem.sv =====
// pls_mem: list store, one write port and one read port with registered data
// no package dependency
`default_nettype none

module pls_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int DW    = 32
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [AW-1:0]        waddr,
	input  wire logic signed [DW-1:0] wdata,
	input  wire logic [AW-1:0]        raddr,
	output logic signed [DW-1:0]      rdata
);

	logic signed [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read before write on a shared address
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/pls_step.sv =====
// pls_step: shared address unit, one increment or decrement and one equality test
// no package dependency; used by pls_ctrl for every address step
`default_nettype none

module pls_step #(
	parameter int W = 7
) (
	input  wire logic [W-1:0] op_a,
	input  wire logic         op_down,
	input  wire logic [W-1:0] cmp_a,
	input  wire logic [W-1:0] cmp_b,
	output logic [W-1:0]      sum,
	output logic              equal
);

	assign sum   = op_down ? (op_a - W'(1)) : (op_a + W'(1));
	assign equal = (cmp_a == cmp_b);

endmodule

`default_nettype wire

// ===== rtl/pls_ctrl.sv =====
// pls_ctrl: request sequencer; checks ranges and moves entries one per cycle
// depends on pls_pkg, pls_step and pls_mem
`default_nettype none

module pls_ctrl #(
	parameter int CAPACITY = 64
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire pls_pkg::item_t  in_item,
	output logic                 res_valid,
	input  wire logic            res_ready,
	output pls_pkg::result_t     res
);

	import pls_pkg::*;

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_FILL,
		S_SHIFT,
		S_PUT,
		S_RDOUT,
		S_DONE
	} state_t;

	state_t      state_q;
	item_t       item_q;
	result_t     res_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_q;
	logic [CW-1:0] src_q;
	logic [CW-1:0] dst_q;

	logic [CMPW-1:0] pos_c;
	logic [CMPW-1:0] cnt_c;
	logic [CW-1:0]   pos_w;
	logic            full;
	logic            is_insert;

	logic [CW-1:0] op_a;
	logic [CW-1:0] cmp_a;
	logic [CW-1:0] cmp_b;
	logic [CW-1:0] step_sum;
	logic          step_eq;

	logic                      mem_we;
	logic [AW-1:0]             mem_waddr;
	logic signed [VALUE_W-1:0] mem_wdata;
	logic signed [VALUE_W-1:0] mem_rdata;

	assign pos_c     = CMPW'(item_q.position);
	assign cnt_c     = CMPW'(count_q);
	assign pos_w     = CW'(item_q.position);
	assign full      = (count_q == CW'(CAPACITY));
	assign is_insert = (item_q.kind == KIND_INSERT);

	// in the check state the unit forms the first read address, later it walks rd_q
	assign op_a  = (state_q == S_CHECK) ? (is_insert ? count_q : pos_w) : rd_q;
	assign cmp_a = is_insert ? src_q : rd_q;
	assign cmp_b = is_insert ? pos_w : count_q;

	pls_step #(
		.W(CW)
	) u_step (
		.op_a   (op_a),
		.op_down(is_insert),
		.cmp_a  (cmp_a),
		.cmp_b  (cmp_b),
		.sum    (step_sum),
		.equal  (step_eq)
	);

	pls_mem #(
		.DEPTH(CAPACITY),
		.AW   (AW),
		.DW   (VALUE_W)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(rd_q[AW-1:0]),
		.rdata(mem_rdata)
	);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = count_q[AW-1:0];
		mem_wdata = item_q.value;
		unique case (state_q)
			S_CHECK: begin
				if (item_q.kind == KIND_APPEND && !full) begin
					mem_we = 1'b1;
				end else if (is_insert && !full && pos_c == cnt_c) begin
					mem_we = 1'b1;
				end
			end
			S_SHIFT: begin
				mem_we    = 1'b1;
				mem_waddr = dst_q[AW-1:0];
				mem_wdata = mem_rdata;
			end
			S_PUT: begin
				// src_q has stopped at the insert position
				mem_we    = 1'b1;
				mem_waddr = src_q[AW-1:0];
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			item_q  <= '0;
			res_q   <= '0;
			rd_q    <= '0;
			src_q   <= '0;
			dst_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						item_q  <= in_item;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					unique case (item_q.kind)
						KIND_APPEND: begin
							if (full) begin
								res_q   <= '{'0, COUNT_W'(count_q), STAT_FULL};
							end else begin
								count_q <= count_q + CW'(1);
								res_q   <= '{'0, COUNT_W'(count_q + CW'(1)), STAT_OK};
							end
							state_q <= S_DONE;
						end
						KIND_INSERT: begin
							if (pos_c > cnt_c) begin
								res_q   <= '{'0, COUNT_W'(count_q), STAT_RANGE};
								state_q <= S_DONE;
							end else if (full) begin
								res_q   <= '{'0, COUNT_W'(count_q), STAT_FULL};
								state_q <= S_DONE;
							end else if (pos_c == cnt_c) begin
								count_q <= count_q + CW'(1);
								res_q   <= '{'0, COUNT_W'(count_q + CW'(1)), STAT_OK};
								state_q <= S_DONE;
							end else begin
								rd_q    <= step_sum;
								src_q   <= count_q;
								state_q <= S_FILL;
							end
						end
						KIND_REMOVE: begin
							if (pos_c >= cnt_c) begin
								res_q   <= '{'0, COUNT_W'(count_q), STAT_RANGE};
								state_q <= S_DONE;
							end else if (step_sum == count_q) begin
								// last entry, nothing to move
								count_q <= count_q - CW'(1);
								res_q   <= '{'0, COUNT_W'(count_q - CW'(1)), STAT_OK};
								state_q <= S_DONE;
							end else begin
								rd_q    <= step_sum;
								src_q   <= pos_w;
								state_q <= S_FILL;
							end
						end
						KIND_READ: begin
							if (pos_c >= cnt_c) begin
								res_q   <= '{'0, COUNT_W'(count_q), STAT_RANGE};
								state_q <= S_DONE;
							end else begin
								rd_q    <= pos_w;
								state_q <= S_FILL;
							end
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_FILL: begin
					src_q <= rd_q;
					dst_q <= src_q;
					rd_q  <= step_sum;
					if (item_q.kind == KIND_READ) begin
						state_q <= S_RDOUT;
					end else begin
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (step_eq) begin
						if (is_insert) begin
							state_q <= S_PUT;
						end else begin
							count_q <= count_q - CW'(1);
							res_q   <= '{'0, COUNT_W'(count_q - CW'(1)), STAT_OK};
							state_q <= S_DONE;
						end
					end else begin
						src_q <= rd_q;
						dst_q <= src_q;
						rd_q  <= step_sum;
					end
				end
				S_PUT: begin
					count_q <= count_q + CW'(1);
					res_q   <= '{'0, COUNT_W'(count_q + CW'(1)), STAT_OK};
					state_q <= S_DONE;
				end
				S_RDOUT: begin
					res_q   <= '{mem_rdata, COUNT_W'(count_q), STAT_OK};
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

endmodule

`default_nettype wire

// ===== rtl/positional_list_store_top.sv =====
// positional_list_store_top: stream ports, field packing and the output register
// depends on pls_pkg and pls_ctrl
//
// channel | dir | tdata (low bit up)              | tuser
// s_*     | in  | position[6:0], value[38:7]      | kind[1:0]
// m_*     | out | read_value[31:0], used_count[38:32] | status[1:0]
//
// one request at a time; append, insert at the count, removal of the last
// entry and failed requests go from check straight to done; other inserts
// and removes pass through fill and shift (inserts also put), reads through
// fill and readout; entries move one per cycle through the single store
// port pair
// reset clears the count and control only; entries above the count are never read
// a result waiting in the output register lets the next request in, but the
// following one stalls until that result is taken
`default_nettype none

module positional_list_store_top #(
	parameter int CAPACITY = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // position[6:0], value[38:7], zero fill
	input  wire logic [1:0]  s_tuser,   // kind[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // read_value[31:0], used_count[38:32], zero fill
	output logic [1:0]       m_tuser    // status[1:0]
);

	import pls_pkg::*;

	item_t   in_item;
	result_t res;
	result_t out_q;
	logic    res_valid;
	logic    res_ready;
	logic    m_tvalid_q;

	assign in_item.kind     = s_tuser;
	assign in_item.position = s_tdata[POS_W-1:0];
	assign in_item.value    = s_tdata[POS_W+VALUE_W-1:POS_W];

	pls_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, out_q.used_count, out_q.read_value};
	assign m_tuser  = out_q.status;

endmodule

`default_nettype wire
